// ===== hw/rtl/lnc_pkg.sv =====
// lnc_pkg: shared types and constants for the LFSR noise channel.
// Item structs, request and register codes, config bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lnc_pkg;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_FRAME   = 2'd1,
		REQ_TRIGGER = 2'd2
	} req_kind_t;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 7;

	localparam logic [CfgIdxW-1:0] CFG_DIVIDER_CODE  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PERIOD_SHIFT  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_NARROW_MODE   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_LEN_STOP      = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_LENGTH_ENABLE = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_DAC_ENABLE    = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_START_VOLUME  = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_ENV_SETTING   = 3'd7;

	localparam int PeriodW = 22;
	localparam int LfsrW   = 16;

	localparam logic [2:0] ENV_STEP  = 3'd7;
	localparam logic [3:0] VOL_MAX   = 4'd15;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] seq_step;
	} req_item_t;

	typedef struct packed {
		logic [3:0] level;
		logic       is_playing;
	} res_item_t;

	typedef struct packed {
		logic [2:0] divider_code;
		logic [3:0] period_shift;
		logic       narrow_mode;
		logic [6:0] len_stop;
		logic       length_enable;
		logic       dac_enable;
		logic [3:0] start_volume;
		logic [3:0] envelope_setting;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lnc_cfg_regs.sv =====
// lnc_cfg_regs: configuration register file of the noise channel.
// Depends on lnc_pkg for cfg_t and register index codes.
`timescale 1ns / 1ps
`default_nettype none
module lnc_cfg_regs
	import lnc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIVIDER_CODE:  cfg_q.divider_code     <= cfg_data[2:0];
				CFG_PERIOD_SHIFT:  cfg_q.period_shift     <= cfg_data[3:0];
				CFG_NARROW_MODE:   cfg_q.narrow_mode      <= cfg_data[0];
				CFG_LEN_STOP:      cfg_q.len_stop         <= cfg_data[6:0];
				CFG_LENGTH_ENABLE: cfg_q.length_enable    <= cfg_data[0];
				CFG_DAC_ENABLE:    cfg_q.dac_enable       <= cfg_data[0];
				CFG_START_VOLUME:  cfg_q.start_volume     <= cfg_data[3:0];
				CFG_ENV_SETTING:   cfg_q.envelope_setting <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lnc_core.sv =====
// lnc_core: channel state and its one-item update.
// Next state and next result are formed combinationally from the staged item.
// Depends on lnc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lnc_core
	import lnc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire req_item_t item,
	input  wire cfg_t      cfg,
	output res_item_t      result
);

	logic [LfsrW-1:0]   shift_q, shift_n;
	logic [PeriodW-1:0] period_q, period_n;
	logic [3:0]         vol_q, vol_n;
	logic [2:0]         env_cnt_q, env_cnt_n;
	logic               env_up_q, env_up_n;
	logic [2:0]         env_pace_q, env_pace_n;
	logic [6:0]         len_q, len_n;
	logic               play_q, play_n;

	logic [6:0]         base;
	logic [PeriodW-1:0] reload;
	logic [PeriodW-1:0] period_dec;
	logic               fb;
	logic [LfsrW-1:0]   lfsr_fill;
	logic [6:0]         len_inc;
	logic [2:0]         env_inc;

	// divisor 8 for code 0, else code*16; shifted, kept to the counter width
	assign base   = (cfg.divider_code == '0) ? 7'd8 : {cfg.divider_code, 4'd0};
	assign reload = {{(PeriodW-7){1'b0}}, base} << cfg.period_shift;

	assign period_dec = period_q - PeriodW'(1);
	assign fb         = (shift_q[0] == shift_q[1]);
	assign len_inc    = len_q + 7'd1;
	assign env_inc    = env_cnt_q + 3'd1;

	always_comb begin
		lfsr_fill = {fb, shift_q[14:0]};
		if (cfg.narrow_mode) begin
			lfsr_fill[7] = fb;
		end
	end

	always_comb begin
		shift_n    = shift_q;
		period_n   = period_q;
		vol_n      = vol_q;
		env_cnt_n  = env_cnt_q;
		env_up_n   = env_up_q;
		env_pace_n = env_pace_q;
		len_n      = len_q;
		play_n     = play_q;
		case (item.req_type)
			REQ_TICK: begin
				if (play_q) begin
					period_n = period_dec;
					if (period_dec == '0) begin
						period_n = reload;
						shift_n  = lfsr_fill >> 1;
					end
				end
			end
			REQ_FRAME: begin
				if (!item.seq_step[0] && cfg.length_enable) begin
					len_n = len_inc;
					if (len_inc >= cfg.len_stop) begin
						play_n = 1'b0;
						len_n  = '0;
					end
				end
				if (item.seq_step == ENV_STEP && env_pace_q != '0) begin
					env_cnt_n = env_inc;
					if (env_inc >= env_pace_q) begin
						env_cnt_n = '0;
						if (env_up_q && vol_q < VOL_MAX) begin
							vol_n = vol_q + 4'd1;
						end else if (!env_up_q && vol_q != '0) begin
							vol_n = vol_q - 4'd1;
						end
					end
				end
			end
			REQ_TRIGGER: begin
				env_cnt_n = '0;
				if (len_q >= cfg.len_stop) begin
					len_n = '0;
				end
				vol_n = cfg.start_volume;
				if (cfg.dac_enable) begin
					play_n = 1'b1;
				end
				shift_n    = '0;
				env_up_n   = cfg.envelope_setting[3];
				env_pace_n = cfg.envelope_setting[2:0];
				period_n   = reload;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= '0;
			period_q   <= '0;
			vol_q      <= '0;
			env_cnt_q  <= '0;
			env_up_q   <= 1'b0;
			env_pace_q <= '0;
			len_q      <= '0;
			play_q     <= 1'b0;
		end else if (advance) begin
			shift_q    <= shift_n;
			period_q   <= period_n;
			vol_q      <= vol_n;
			env_cnt_q  <= env_cnt_n;
			env_up_q   <= env_up_n;
			env_pace_q <= env_pace_n;
			len_q      <= len_n;
			play_q     <= play_n;
		end
	end

	assign result.level      = shift_n[0] ? 4'd0 : vol_n;
	assign result.is_playing = play_n;

endmodule
`default_nettype wire

// ===== hw/rtl/lfsr_noise_channel.sv =====
// Noise channel top: request staging register, state update, result register.
// Flow: an accepted item waits in the request staging register; res_valid rises when
// it advances into the result register. Throughput: 1 item/cycle unless the result
// register stalls, set by the combinational state update in lnc_core between the registers.
// Reset (arst_n low, asynchronous): all state, config and valid flags clear;
// the channel starts stopped with a zero LFSR and zero volume.
`timescale 1ns / 1ps
`default_nettype none
module lfsr_noise_channel
	import lnc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire req_item_t           req,
	// result channel
	output logic                     res_valid,
	input  wire logic                res_ready,
	output res_item_t                res,
	// config write port
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	cfg_t      cfg;
	req_item_t req_s1;
	logic      valid_s1;
	logic      advance;
	res_item_t core_res;
	res_item_t res_q;
	logic      res_valid_q;

	// staged item moves on whenever the result register is free or being drained
	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	// the stage takes a new item when empty or emptying this cycle
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	lnc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state commits only when the staged item advances, so each item hits once
	lnc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (req_s1),
		.cfg     (cfg),
		.result  (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lnc_checker.sv =====
// lnc_checker: port-level assertions for lfsr_noise_channel, plus its bind.
// Depends on lnc_pkg for the item structs.
`timescale 1ns / 1ps
`default_nettype none
module lnc_checker
	import lnc_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire req_item_t req,
	input wire logic      res_valid,
	input wire logic      res_ready,
	input wire res_item_t res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// an empty output side never back-pressures requests
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("request stalled with empty result register");

	// a drained result frees room for a new request in the same cycle
	a_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> req_ready)
		else $error("request stalled while result drains");

	// an accepted request shows a result once it has passed the staging and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 res_valid)
		else $error("no result two cycles after accept");

endmodule

bind lfsr_noise_channel lnc_checker u_lnc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire
